>>> rtl/core/lef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lef_pkg
// Shared types and constants of the line editor escape filter.
// ----------------------------------------------------------------------------
package lef_pkg;

  localparam int unsigned LEF_MAX_LINE = 4096;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned CAP_W   = 13;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned INNER_W = 6;
  localparam int unsigned STR_W   = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;

  // Echo codes
  localparam logic [KIND_W-1:0] ECHO_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] ECHO_CHAR  = 2'd1;
  localparam logic [KIND_W-1:0] ECHO_CRLF  = 2'd2;
  localparam logic [KIND_W-1:0] ECHO_ERASE = 2'd3;

  // Byte codes
  localparam logic [BYTE_W-1:0] CH_BEL   = 8'h07;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRK  = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CH_X     = 8'h58;
  localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;

  // Run limits
  localparam logic [INNER_W-1:0] CSI_LIMIT    = 6'd32;
  localparam logic [INNER_W-1:0] INTER_LIMIT  = 6'd8;
  localparam logic [STR_W-1:0]   STRING_LIMIT = 9'd256;

  // Parser view handed to the line unit
  typedef struct packed {
    logic ground;  // parser idle: byte goes to the line editor
  } parse_ctl_t;

  // One result item
  typedef struct packed {
    logic [KIND_W-1:0] echo_kind;
    logic [BYTE_W-1:0] out_char;
    logic              store_valid;
    logic [LEN_W-1:0]  store_index;
    logic              line_done;
    logic [LEN_W-1:0]  line_length;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/lef_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lef_parser
// ANSI escape parser: tracks open CSI, SS3, intermediate runs and strings.
// ----------------------------------------------------------------------------
module lef_parser (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire logic [lef_pkg::BYTE_W-1:0] byte_in,
  output lef_pkg::parse_ctl_t            ctl
);
  import lef_pkg::*;

  localparam logic [PHASE_W-1:0] PH_GROUND    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_ESC       = 4'd1;
  localparam logic [PHASE_W-1:0] PH_CSI       = 4'd2;
  localparam logic [PHASE_W-1:0] PH_SS3       = 4'd3;
  localparam logic [PHASE_W-1:0] PH_INTER     = 4'd4;
  localparam logic [PHASE_W-1:0] PH_STR       = 4'd5;
  localparam logic [PHASE_W-1:0] PH_STR_ESC   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_STR_CSI   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_STR_SS3   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_STR_INTER = 4'd9;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [INNER_W-1:0] inner_count, inner_count_next;
  logic [STR_W-1:0]   string_count, string_count_next;

  logic [INNER_W-1:0] inner_inc;
  logic [STR_W-1:0]   string_inc;
  logic [PHASE_W-1:0] step_done_phase;
  logic               csi_final, inter_final, inter_start, str_open;

  assign inner_inc   = inner_count + 1'b1;
  assign string_inc  = string_count + 1'b1;
  assign csi_final   = (byte_in >= CH_AT) && (byte_in <= CH_TILDE);
  assign inter_final = (byte_in >= CH_ZERO) && (byte_in <= CH_TILDE);
  assign inter_start = (byte_in >= CH_SPACE) && (byte_in <= CH_SLASH);
  assign str_open    = (byte_in == CH_RBRK) || (byte_in == CH_P) || (byte_in == CH_X) ||
                       (byte_in == CH_CARET) || (byte_in == CH_UNDER);
  // A finished string step returns to ground once the string runs out of steps
  assign step_done_phase = (string_inc >= STRING_LIMIT) ? PH_GROUND : PH_STR;

  always_comb begin
    phase_next        = phase;
    inner_count_next  = inner_count;
    string_count_next = string_count;
    case (phase)
      PH_GROUND: begin
        if (byte_in == CH_ESC) phase_next = PH_ESC;
      end
      PH_ESC: begin
        if (byte_in == CH_LBRK) begin
          phase_next       = PH_CSI;
          inner_count_next = '0;
        end else if (byte_in == CH_O) begin
          phase_next = PH_SS3;
        end else if (str_open) begin
          phase_next        = PH_STR;
          string_count_next = '0;
        end else if (inter_start) begin
          phase_next       = PH_INTER;
          inner_count_next = '0;
        end else begin
          phase_next = PH_GROUND;
        end
      end
      PH_CSI: begin
        inner_count_next = inner_inc;
        if (csi_final || inner_inc >= CSI_LIMIT) phase_next = PH_GROUND;
      end
      PH_SS3: begin
        phase_next = PH_GROUND;
      end
      PH_INTER: begin
        inner_count_next = inner_inc;
        if (inter_final || inner_inc >= INTER_LIMIT) phase_next = PH_GROUND;
      end
      PH_STR: begin
        if (byte_in == CH_BEL) begin
          phase_next = PH_GROUND;
        end else if (byte_in == CH_ESC) begin
          phase_next = PH_STR_ESC;
        end else begin
          string_count_next = string_inc;
          phase_next        = step_done_phase;
        end
      end
      PH_STR_ESC: begin
        if (byte_in == CH_BSL) begin
          phase_next = PH_GROUND;
        end else if (byte_in == CH_LBRK) begin
          phase_next       = PH_STR_CSI;
          inner_count_next = '0;
        end else if (byte_in == CH_O) begin
          phase_next = PH_STR_SS3;
        end else if (inter_start) begin
          phase_next       = PH_STR_INTER;
          inner_count_next = '0;
        end else begin
          string_count_next = string_inc;
          phase_next        = step_done_phase;
        end
      end
      PH_STR_CSI: begin
        inner_count_next = inner_inc;
        if (csi_final || inner_inc >= CSI_LIMIT) begin
          string_count_next = string_inc;
          phase_next        = step_done_phase;
        end
      end
      PH_STR_SS3: begin
        string_count_next = string_inc;
        phase_next        = step_done_phase;
      end
      PH_STR_INTER: begin
        inner_count_next = inner_inc;
        if (inter_final || inner_inc >= INTER_LIMIT) begin
          string_count_next = string_inc;
          phase_next        = step_done_phase;
        end
      end
      default: begin
        phase_next = PH_GROUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_GROUND;
      inner_count  <= '0;
      string_count <= '0;
    end else if (step) begin
      phase        <= phase_next;
      inner_count  <= inner_count_next;
      string_count <= string_count_next;
    end
  end

  assign ctl.ground = (phase == PH_GROUND);

endmodule
`default_nettype wire

>>> rtl/core/lef_line.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lef_line
// Line length keeper: echo, store, erase and line completion per byte.
// ----------------------------------------------------------------------------
module lef_line #(
  parameter int unsigned MAX_LINE = lef_pkg::LEF_MAX_LINE
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire logic [lef_pkg::BYTE_W-1:0] byte_in,
  input  wire logic [lef_pkg::CAP_W-1:0]  capacity,
  input  wire lef_pkg::parse_ctl_t       ctl,
  output lef_pkg::result_t               result
);
  import lef_pkg::*;

  localparam logic [31:0] MAX_LINE_W = 32'(MAX_LINE);

  logic [LEN_W-1:0] held_length, held_length_next;
  logic [LEN_W-1:0] len_after;
  logic [CAP_W-1:0] cap_a, cap_b, lim_wide;
  logic [LEN_W-1:0] limit;
  logic             is_newline, is_erase, is_print;

  // Capacity 0 counts as 1, clamp to the line maximum, limit tops out at 4095
  always_comb begin
    cap_a = (capacity == '0) ? CAP_W'(1) : capacity;
    cap_b = (32'(cap_a) > MAX_LINE_W) ? MAX_LINE_W[CAP_W-1:0] : cap_a;
    lim_wide = cap_b - 1'b1;
    limit = lim_wide[CAP_W-1] ? {LEN_W{1'b1}} : lim_wide[LEN_W-1:0];
  end

  assign is_newline = (byte_in == CH_CR) || (byte_in == CH_LF);
  assign is_erase   = (byte_in == CH_BS) || (byte_in == CH_DEL);
  assign is_print   = (byte_in >= CH_SPACE) && (byte_in <= CH_TILDE);

  always_comb begin
    result    = '0;
    len_after = held_length;
    if (ctl.ground && byte_in != CH_ESC) begin
      if (is_newline) begin
        result.echo_kind = ECHO_CRLF;
        result.line_done = 1'b1;
      end else if (is_erase) begin
        if (held_length != '0) begin
          result.echo_kind = ECHO_ERASE;
          len_after        = held_length - 1'b1;
        end
      end else if (is_print) begin
        result.echo_kind = ECHO_CHAR;
        result.out_char  = byte_in;
        if (held_length < limit) begin
          result.store_valid = 1'b1;
          result.store_index = held_length;
          len_after          = held_length + 1'b1;
        end
      end
      if (len_after >= limit) result.line_done = 1'b1;
    end
    result.line_length = len_after;
    held_length_next   = result.line_done ? '0 : len_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_length <= '0;
    end else if (step) begin
      held_length <= held_length_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/line_editor_escape_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_editor_escape_filter_top
// Terminal line editor front end that swallows ANSI escape sequences.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | in_byte
//  out     | out_valid / out_ready| echo_kind, out_char, store_valid,
//          |                      | store_index, line_done, line_length
//  cfg     | cfg_valid / cfg_ready| line_capacity
//
//  A byte accepted into the input register advances into the parser and line
//  update, which load the result register, once that register is empty or
//  being drained. One byte per cycle is sustained while out_ready stays high.
//  Reset clears the parser to ground, the held length to zero and the capacity
//  to 256. A stalled result holds the next request in the input register; both
//  registers full drops in_ready.
// ----------------------------------------------------------------------------
module line_editor_escape_filter_top #(
  parameter int unsigned MAX_LINE = lef_pkg::LEF_MAX_LINE
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic [lef_pkg::BYTE_W-1:0] in_byte,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [lef_pkg::KIND_W-1:0] echo_kind,
  output      logic [lef_pkg::BYTE_W-1:0] out_char,
  output      logic                       store_valid,
  output      logic [lef_pkg::LEN_W-1:0]  store_index,
  output      logic                       line_done,
  output      logic [lef_pkg::LEN_W-1:0]  line_length,
  input  wire logic                       cfg_valid,
  output      logic                       cfg_ready,
  input  wire logic [lef_pkg::CAP_W-1:0]  line_capacity
);
  import lef_pkg::*;

  logic              held_valid;   // input register occupied
  logic [BYTE_W-1:0] held_byte;
  logic              advance;      // move held byte into the result register
  logic [CAP_W-1:0]  capacity;
  parse_ctl_t        ctl;
  result_t           result_d, result_q;

  // Advance whenever the result register is empty or being drained
  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;
  // Capacity writes are for the user to make only while idle; the block does not enforce it, so take them at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= line_capacity;
    end
  end

  // Input register: load on accept, drop after advance
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) held_byte <= in_byte;
  end

  lef_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (held_byte),
    .ctl     (ctl)
  );

  lef_line #(
    .MAX_LINE (MAX_LINE)
  ) u_line (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .byte_in  (held_byte),
    .capacity (capacity),
    .ctl      (ctl),
    .result   (result_d)
  );

  // Result register: hold while stalled, clear valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result_q <= result_d;
  end

  assign echo_kind   = result_q.echo_kind;
  assign out_char    = result_q.out_char;
  assign store_valid = result_q.store_valid;
  assign store_index = result_q.store_index;
  assign line_done   = result_q.line_done;
  assign line_length = result_q.line_length;

endmodule
`default_nettype wire

>>> rtl/core/lef_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lef_checker
// Port-level checks of the escape filter, bound to the top level.
// ----------------------------------------------------------------------------
module lef_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [lef_pkg::KIND_W-1:0] echo_kind,
  input wire logic [lef_pkg::BYTE_W-1:0] out_char,
  input wire logic                       store_valid,
  input wire logic [lef_pkg::LEN_W-1:0]  store_index,
  input wire logic                       line_done,
  input wire logic [lef_pkg::LEN_W-1:0]  line_length
);
  import lef_pkg::*;

  // A stored character is always an echoed one, and extends the line by one
  a_store_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && store_valid |-> echo_kind == ECHO_CHAR &&
      line_length == store_index + 1'b1)
    else $error("store does not match echo or length");

  // Newline always finishes the line
  a_crlf_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && echo_kind == ECHO_CRLF |-> line_done)
    else $error("CR LF echo without line completion");

  // Character field is only populated for a character echo
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && echo_kind != ECHO_CHAR |-> out_char == '0)
    else $error("out_char set without character echo");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line_length) && $stable(echo_kind))
    else $error("result changed while stalled");

endmodule

bind line_editor_escape_filter_top lef_checker u_lef_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .echo_kind   (echo_kind),
  .out_char    (out_char),
  .store_valid (store_valid),
  .store_index (store_index),
  .line_done   (line_done),
  .line_length (line_length)
);
`default_nettype wire
